>>> rtl/ptmhq_pkg.sv
// ----------------------------------------------------------------------------
// ptmhq_pkg
// Shared types, codes and helpers for the priority/ttl min-heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ptmhq_pkg;

    // default number of heap slots
    localparam int QUEUE_DEPTH = 64;

    // field widths
    localparam int PRIO_W = 3;
    localparam int TTL_W  = 16;
    localparam int ID_W   = 32;
    localparam int OCC_W  = 7;
    localparam int KEY_W  = 18;

    // key = prio * scale + ttl
    localparam logic [KEY_W-1:0] PRIO_SCALE = KEY_W'(10000);

    // input command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_FULL   = 2'd1,
        ST_POPPED = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // one stored heap entry
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TTL_W-1:0]  ttl;
        logic [ID_W-1:0]   id;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic    load_push;  // take input word, open hole at the tail
        logic    pop_rd;     // read root and last entry
        logic    load_pop;   // latch root, hold last entry, open hole at root
        logic    su_rd;      // read parent of hole
        logic    su_step;    // move parent down into hole
        logic    sd_rd;      // read both children of hole
        logic    sd_step;    // move smaller child up into hole
        logic    place;      // write held entry into hole
        logic    finish;     // load result registers
        status_t code;       // status of the finished word
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic parent_le;
        logic child_less;
    } dp_stat_t;

    // ordering key of an entry
    function automatic logic [KEY_W-1:0] key_of(input entry_t e);
        return KEY_W'(e.prio) * PRIO_SCALE + KEY_W'(e.ttl);
    endfunction

endpackage

`default_nettype wire

>>> rtl/priority_ttl_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// priority_ttl_min_heap_queue_top
// Bounded binary min-heap of message entries ordered by prio*10000 + ttl.
//
//   channel   signals                                   direction
//   command   start, busy, cmd, prio, ttl, msg_id       in (busy out)
//   result    done, status, out_prio, out_ttl, out_id,  out
//             occupancy
//
// A word is taken at a rising edge with start high and busy low; its result
// is shown for one cycle with done high. A rejected push or an empty pop is
// answered straight from idle, with done raised by the accepting edge itself.
// A push climbs one level per read and compare on the heap memory until its
// parent is no larger or it reaches the root; a pop reads the root and the
// last entry, then sinks the last entry one level per read and compare. busy
// stays high until the word is finished; the receiver cannot stall the block.
// Reset leaves the heap empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ttl_min_heap_queue_top #(
    parameter int QUEUE_DEPTH = ptmhq_pkg::QUEUE_DEPTH
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                cmd,
    input  wire [ptmhq_pkg::PRIO_W-1:0]        prio,
    input  wire [ptmhq_pkg::TTL_W-1:0]         ttl,
    input  wire [ptmhq_pkg::ID_W-1:0]          msg_id,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [ptmhq_pkg::PRIO_W-1:0]       out_prio,
    output logic [ptmhq_pkg::TTL_W-1:0]        out_ttl,
    output logic [ptmhq_pkg::ID_W-1:0]         out_id,
    output logic [ptmhq_pkg::OCC_W-1:0]        occupancy
);

    ptmhq_pkg::ctl_cmd_t ctl;
    ptmhq_pkg::dp_stat_t stat;

    // sequencer
    ptmhq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // heap datapath
    ptmhq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .prio      (prio),
        .ttl       (ttl),
        .msg_id    (msg_id),
        .status    (status),
        .out_prio  (out_prio),
        .out_ttl   (out_ttl),
        .out_id    (out_id),
        .occupancy (occupancy)
    );

endmodule

`default_nettype wire

>>> rtl/ptmhq_ram.sv
// ----------------------------------------------------------------------------
// ptmhq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr_a,
    output logic [WIDTH-1:0]          rdata_a,
    input  wire [$clog2(DEPTH)-1:0]   raddr_b,
    output logic [WIDTH-1:0]          rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

>>> rtl/ptmhq_ctrl.sv
// ----------------------------------------------------------------------------
// ptmhq_ctrl
// Sequencer for push (sift up) and pop (sift down) over the heap memory.
// ----------------------------------------------------------------------------
`default_nettype none

module ptmhq_ctrl (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire                        cmd,
    input  wire ptmhq_pkg::dp_stat_t   stat,
    output ptmhq_pkg::ctl_cmd_t        ctl,
    output logic                       busy,
    output logic                       done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_LD,
        S_SU_RD,
        S_SU_CMP,
        S_SD_RD,
        S_SD_CMP
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    // next state and commands
    always_comb
    begin
        ctl        = '0;
        ctl.code   = ptmhq_pkg::ST_PUSHED;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == ptmhq_pkg::CMD_PUSH)
                    begin
                        if (stat.full)
                        begin
                            ctl.finish = 1'b1;
                            ctl.code   = ptmhq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.load_push = 1'b1;
                            state_next    = S_SU_RD;
                        end
                    end
                    else
                    begin
                        if (stat.empty)
                        begin
                            ctl.finish = 1'b1;
                            ctl.code   = ptmhq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ctl.pop_rd = 1'b1;
                            state_next = S_POP_LD;
                        end
                    end
                end
            end
            S_POP_LD:
            begin
                ctl.load_pop = 1'b1;
                state_next   = S_SD_RD;
            end
            S_SU_RD:
            begin
                if (stat.at_root)
                begin
                    ctl.place  = 1'b1;
                    ctl.finish = 1'b1;
                    ctl.code   = ptmhq_pkg::ST_PUSHED;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.su_rd  = 1'b1;
                    state_next = S_SU_CMP;
                end
            end
            S_SU_CMP:
            begin
                if (stat.parent_le)
                begin
                    ctl.place  = 1'b1;
                    ctl.finish = 1'b1;
                    ctl.code   = ptmhq_pkg::ST_PUSHED;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.su_step = 1'b1;
                    state_next  = S_SU_RD;
                end
            end
            S_SD_RD:
            begin
                ctl.sd_rd  = 1'b1;
                state_next = S_SD_CMP;
            end
            S_SD_CMP:
            begin
                if (stat.child_less)
                begin
                    ctl.sd_step = 1'b1;
                    state_next  = S_SD_RD;
                end
                else
                begin
                    ctl.place  = 1'b1;
                    ctl.finish = 1'b1;
                    ctl.code   = ptmhq_pkg::ST_POPPED;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
        done_next = ctl.finish;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    // a result is only shown once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobe while busy");

    // a finished word always produces exactly one strobe
    a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> done_reg)
        else $error("finish without result strobe");

endmodule

`default_nettype wire

>>> rtl/ptmhq_dpath.sv
// ----------------------------------------------------------------------------
// ptmhq_dpath
// Heap datapath: entry count, hole pointer, held entry, key compares, results.
// ----------------------------------------------------------------------------
`default_nettype none

module ptmhq_dpath #(
    parameter int QUEUE_DEPTH = ptmhq_pkg::QUEUE_DEPTH
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire ptmhq_pkg::ctl_cmd_t           ctl,
    output ptmhq_pkg::dp_stat_t                stat,
    input  wire [ptmhq_pkg::PRIO_W-1:0]        prio,
    input  wire [ptmhq_pkg::TTL_W-1:0]         ttl,
    input  wire [ptmhq_pkg::ID_W-1:0]          msg_id,
    output logic [1:0]                         status,
    output logic [ptmhq_pkg::PRIO_W-1:0]       out_prio,
    output logic [ptmhq_pkg::TTL_W-1:0]        out_ttl,
    output logic [ptmhq_pkg::ID_W-1:0]         out_id,
    output logic [ptmhq_pkg::OCC_W-1:0]        occupancy
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = AW + 2;
    localparam int EW = $bits(ptmhq_pkg::entry_t);

    logic [CW-1:0]       count_reg;
    logic [AW-1:0]       hole_reg;
    ptmhq_pkg::entry_t   item_reg;
    ptmhq_pkg::entry_t   root_reg;
    ptmhq_pkg::status_t  status_reg;
    ptmhq_pkg::entry_t   out_reg;
    logic [ptmhq_pkg::OCC_W-1:0] occ_reg;

    ptmhq_pkg::entry_t   rd_a, rd_b, wdata;
    logic [AW-1:0]       raddr_a, raddr_b;
    logic                we;

    logic [CW-1:0]       count_dec;
    logic [AW-1:0]       hole_dec, parent_idx;
    logic [XW-1:0]       l_idx, r_idx, count_x;
    logic                l_ok, r_ok, take_l, take_r;
    logic [ptmhq_pkg::KEY_W-1:0] key_item, key_a, key_b, key_best;
    logic [CW+ptmhq_pkg::OCC_W-1:0] occ_ext;

    // index arithmetic
    assign count_dec  = count_reg - CW'(1);
    assign hole_dec   = hole_reg - AW'(1);
    assign parent_idx = hole_dec >> 1;
    assign l_idx      = {1'b0, hole_reg, 1'b1};
    assign r_idx      = l_idx + XW'(1);
    assign count_x    = {{(XW-CW){1'b0}}, count_reg};
    assign l_ok       = (l_idx < count_x);
    assign r_ok       = (r_idx < count_x);

    // key compares, left child first then right against the running best
    assign key_item = ptmhq_pkg::key_of(item_reg);
    assign key_a    = ptmhq_pkg::key_of(rd_a);
    assign key_b    = ptmhq_pkg::key_of(rd_b);
    assign take_l   = l_ok && (key_a < key_item);
    assign key_best = take_l ? key_a : key_item;
    assign take_r   = r_ok && (key_b < key_best);

    // status to the controller
    assign stat.full       = (count_reg == CW'(QUEUE_DEPTH));
    assign stat.empty      = (count_reg == '0);
    assign stat.at_root    = (hole_reg == '0);
    assign stat.parent_le  = (key_a <= key_item);
    assign stat.child_less = take_l || take_r;

    // memory read addresses
    always_comb
    begin
        raddr_a = '0;
        raddr_b = '0;
        priority if (ctl.pop_rd)
        begin
            raddr_b = count_dec[AW-1:0];
        end
        else if (ctl.su_rd)
        begin
            raddr_a = parent_idx;
        end
        else if (ctl.sd_rd)
        begin
            raddr_a = l_idx[AW-1:0];
            raddr_b = r_idx[AW-1:0];
        end
    end

    // memory write into the hole
    always_comb
    begin
        we    = ctl.place || ctl.su_step || ctl.sd_step;
        wdata = item_reg;
        priority if (ctl.place)
        begin
            wdata = item_reg;
        end
        else if (ctl.su_step)
        begin
            wdata = rd_a;
        end
        else if (ctl.sd_step)
        begin
            wdata = take_r ? rd_b : rd_a;
        end
    end

    ptmhq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (hole_reg),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rd_a),
        .raddr_b (raddr_b),
        .rdata_b (rd_b)
    );

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.load_push)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (ctl.load_pop)
        begin
            count_reg <= count_dec;
        end
    end

    // hole pointer and held entries
    always_ff @(posedge clk)
    begin
        if (ctl.load_push)
        begin
            hole_reg      <= count_reg[AW-1:0];
            item_reg.prio <= prio;
            item_reg.ttl  <= ttl;
            item_reg.id   <= msg_id;
        end
        else if (ctl.load_pop)
        begin
            hole_reg <= '0;
            item_reg <= rd_b;
            root_reg <= rd_a;
        end
        else if (ctl.su_step)
        begin
            hole_reg <= parent_idx;
        end
        else if (ctl.sd_step)
        begin
            hole_reg <= take_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
        end
    end

    // result registers
    assign occ_ext = {{ptmhq_pkg::OCC_W{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            status_reg <= ctl.code;
            out_reg    <= (ctl.code == ptmhq_pkg::ST_POPPED) ? root_reg : '0;
            occ_reg    <= occ_ext[ptmhq_pkg::OCC_W-1:0];
        end
    end

    assign status    = status_reg;
    assign out_prio  = out_reg.prio;
    assign out_ttl   = out_reg.ttl;
    assign out_id    = out_reg.id;
    assign occupancy = occ_reg;

    // count never passes the number of slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    // push is never opened on a full heap
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_push |-> !stat.full)
        else $error("push started on full heap");

    // sift up walks toward the root, sift down away from it
    a_su_dir: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.su_step |=> hole_reg < $past(hole_reg))
        else $error("sift up did not move toward root");

    a_sd_dir: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sd_step |=> hole_reg > $past(hole_reg))
        else $error("sift down did not move toward leaves");

endmodule

`default_nettype wire

>>> test/ptmhq_checker.sv
// ----------------------------------------------------------------------------
// ptmhq_checker
// Watches the command and result channels of the priority/ttl min-heap queue.
// It keeps a mirror of the heap, works out the result word for each command
// word the block accepts, and compares every result word field by field with
// the oldest one still owed.
// ----------------------------------------------------------------------------
module ptmhq_checker #(
    parameter int DEPTH = ptmhq_pkg::QUEUE_DEPTH
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire                            busy,
    input  wire                            cmd,
    input  wire [ptmhq_pkg::PRIO_W-1:0]    prio,
    input  wire [ptmhq_pkg::TTL_W-1:0]     ttl,
    input  wire [ptmhq_pkg::ID_W-1:0]      msg_id,
    input  wire                            done,
    input  wire [1:0]                      status,
    input  wire [ptmhq_pkg::PRIO_W-1:0]    out_prio,
    input  wire [ptmhq_pkg::TTL_W-1:0]     out_ttl,
    input  wire [ptmhq_pkg::ID_W-1:0]      out_id,
    input  wire [ptmhq_pkg::OCC_W-1:0]     occupancy,
    output int                             fail_count,
    output int                             words_waiting,
    output int                             push_total,
    output int                             full_total,
    output int                             pop_total,
    output int                             empty_total,
    output int                             peak_occupancy
);

    // one result word as the block should report it
    typedef struct {
        ptmhq_pkg::status_t            code;
        logic [ptmhq_pkg::PRIO_W-1:0]  prio;
        logic [ptmhq_pkg::TTL_W-1:0]   ttl;
        logic [ptmhq_pkg::ID_W-1:0]    id;
        logic [ptmhq_pkg::OCC_W-1:0]   occ;
    } result_word_t;

    ptmhq_pkg::entry_t mirror_heap [DEPTH];
    int                mirror_count = 0;
    result_word_t      owed_results [$];

    int mismatches   = 0;
    int pending      = 0;
    int pushes_seen  = 0;
    int fulls_seen   = 0;
    int pops_seen    = 0;
    int empties_seen = 0;
    int peak_seen    = 0;

    assign fail_count     = mismatches;
    assign words_waiting  = pending;
    assign push_total     = pushes_seen;
    assign full_total     = fulls_seen;
    assign pop_total      = pops_seen;
    assign empty_total    = empties_seen;
    assign peak_occupancy = peak_seen;

    // ordering key: priority weighs 10000 ms of ttl
    function automatic int heap_rank(input ptmhq_pkg::entry_t e);
        return int'(e.prio) * int'(ptmhq_pkg::PRIO_SCALE) + int'(e.ttl);
    endfunction

    function automatic void swap_entries(input int a, input int b);
        ptmhq_pkg::entry_t held;
        held           = mirror_heap[a];
        mirror_heap[a] = mirror_heap[b];
        mirror_heap[b] = held;
    endfunction

    // apply one command word to the mirror and give the result it owes
    function automatic void heap_operation(input logic op, input ptmhq_pkg::entry_t e,
                                           output result_word_t r);
        int slot;
        int parent;
        int best;
        int left;
        int right;
        r.code = ptmhq_pkg::ST_PUSHED;
        r.prio = '0;
        r.ttl  = '0;
        r.id   = '0;
        if (op == ptmhq_pkg::CMD_PUSH)
        begin
            if (mirror_count >= DEPTH)
            begin
                r.code = ptmhq_pkg::ST_FULL;
            end
            else
            begin
                // append at the tail and climb while the parent is strictly larger
                slot              = mirror_count;
                mirror_heap[slot] = e;
                mirror_count++;
                while (slot > 0)
                begin
                    parent = (slot - 1) / 2;
                    if (heap_rank(mirror_heap[parent]) <= heap_rank(mirror_heap[slot]))
                        break;
                    swap_entries(parent, slot);
                    slot = parent;
                end
            end
        end
        else
        begin
            if (mirror_count == 0)
            begin
                r.code = ptmhq_pkg::ST_EMPTY;
            end
            else
            begin
                // hand out the root, refill it from the tail and sink it
                r.code = ptmhq_pkg::ST_POPPED;
                r.prio = mirror_heap[0].prio;
                r.ttl  = mirror_heap[0].ttl;
                r.id   = mirror_heap[0].id;
                mirror_count--;
                mirror_heap[0] = mirror_heap[mirror_count];
                slot = 0;
                forever
                begin
                    best  = slot;
                    left  = 2 * slot + 1;
                    right = 2 * slot + 2;
                    if (left < mirror_count &&
                        heap_rank(mirror_heap[left]) < heap_rank(mirror_heap[best]))
                        best = left;
                    if (right < mirror_count &&
                        heap_rank(mirror_heap[right]) < heap_rank(mirror_heap[best]))
                        best = right;
                    if (best == slot)
                        break;
                    swap_entries(best, slot);
                    slot = best;
                end
            end
        end
        r.occ = ptmhq_pkg::OCC_W'(mirror_count);
        if (mirror_count > peak_seen)
            peak_seen = mirror_count;
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // check result words first, then take any command word accepted at this edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_word_t      want;
        ptmhq_pkg::entry_t taken;
        if (!rst_n)
        begin
            mirror_count = 0;
            owed_results.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with none expected, status %0h occupancy %0d",
                             $time, status, occupancy);
                end
                else
                begin
                    want = owed_results.pop_front();
                    compare_field("status", want.code, status);
                    compare_field("out_prio", want.prio, out_prio);
                    compare_field("out_ttl", want.ttl, out_ttl);
                    compare_field("out_id", want.id, out_id);
                    compare_field("occupancy", want.occ, occupancy);
                    case (want.code)
                        ptmhq_pkg::ST_PUSHED: pushes_seen++;
                        ptmhq_pkg::ST_FULL:   fulls_seen++;
                        ptmhq_pkg::ST_POPPED: pops_seen++;
                        default:              empties_seen++;
                    endcase
                end
            end
            if (start && !busy)
            begin
                taken.prio = prio;
                taken.ttl  = ttl;
                taken.id   = msg_id;
                heap_operation(cmd, taken, want);
                owed_results.push_back(want);
            end
            pending = owed_results.size();
        end
    end

endmodule

>>> test/tb_priority_ttl_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// tb_priority_ttl_min_heap_queue_top
// Drives command words into the min-heap queue: a directed opening covering
// empty pops, key extremes and equal keys across and within priorities, then
// random bursts that fill, drain and churn the heap so it reaches full and
// empty many times. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_priority_ttl_min_heap_queue_top;

    localparam int RANDOM_WORDS = 900;
    localparam int TAIL_CYCLES  = 2 * $clog2(ptmhq_pkg::QUEUE_DEPTH) + 12;

    logic                           clk    = 1'b0;
    logic                           rst_n  = 1'b0;
    logic                           start  = 1'b0;
    logic                           cmd    = ptmhq_pkg::CMD_PUSH;
    logic [ptmhq_pkg::PRIO_W-1:0]   prio   = '0;
    logic [ptmhq_pkg::TTL_W-1:0]    ttl    = '0;
    logic [ptmhq_pkg::ID_W-1:0]     msg_id = '0;

    wire                            busy;
    wire                            done;
    wire [1:0]                      status;
    wire [ptmhq_pkg::PRIO_W-1:0]    out_prio;
    wire [ptmhq_pkg::TTL_W-1:0]     out_ttl;
    wire [ptmhq_pkg::ID_W-1:0]      out_id;
    wire [ptmhq_pkg::OCC_W-1:0]     occupancy;

    int fail_count;
    int words_waiting;
    int push_total;
    int full_total;
    int pop_total;
    int empty_total;
    int peak_occupancy;

    int idle_pct   = 15;
    int words_sent = 0;

    // clock
    always #10 clk = ~clk;

    priority_ttl_min_heap_queue_top #(
        .QUEUE_DEPTH (ptmhq_pkg::QUEUE_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .prio      (prio),
        .ttl       (ttl),
        .msg_id    (msg_id),
        .done      (done),
        .status    (status),
        .out_prio  (out_prio),
        .out_ttl   (out_ttl),
        .out_id    (out_id),
        .occupancy (occupancy)
    );

    ptmhq_checker #(
        .DEPTH (ptmhq_pkg::QUEUE_DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .prio           (prio),
        .ttl            (ttl),
        .msg_id         (msg_id),
        .done           (done),
        .status         (status),
        .out_prio       (out_prio),
        .out_ttl        (out_ttl),
        .out_id         (out_id),
        .occupancy      (occupancy),
        .fail_count     (fail_count),
        .words_waiting  (words_waiting),
        .push_total     (push_total),
        .full_total     (full_total),
        .pop_total      (pop_total),
        .empty_total    (empty_total),
        .peak_occupancy (peak_occupancy)
    );

    // offer one word, with random idle cycles ahead of it, until it is taken
    task automatic send_word(input logic op, input logic [ptmhq_pkg::PRIO_W-1:0] p,
                             input logic [ptmhq_pkg::TTL_W-1:0] t,
                             input logic [ptmhq_pkg::ID_W-1:0] id);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        cmd    <= op;
        prio   <= p;
        ttl    <= t;
        msg_id <= id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
    endtask

    // stop offering until every owed result word has come back
    task automatic drain_results;
        start <= 1'b0;
        @(negedge clk);
        while (words_waiting != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                           sent;
        int                           burst_len;
        int                           push_pct;
        logic                         op;
        logic [ptmhq_pkg::PRIO_W-1:0] p;
        logic [ptmhq_pkg::TTL_W-1:0]  t;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, key extremes, equal keys, then drain past empty
        send_word(ptmhq_pkg::CMD_POP, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(ptmhq_pkg::CMD_PUSH, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(ptmhq_pkg::CMD_PUSH, 3'd0, 16'd0, 32'h0000_0000);
        send_word(ptmhq_pkg::CMD_PUSH, 3'd1, 16'd0, 32'hA5A5_0001);
        send_word(ptmhq_pkg::CMD_PUSH, 3'd0, 16'd10000, 32'h5A5A_0002);
        send_word(ptmhq_pkg::CMD_PUSH, 3'd1, 16'd0, 32'hA5A5_0003);
        send_word(ptmhq_pkg::CMD_PUSH, 3'd0, 16'hFFFF, 32'h0F0F_0004);
        send_word(ptmhq_pkg::CMD_PUSH, 3'd6, 16'd0, 32'hF0F0_0005);
        send_word(ptmhq_pkg::CMD_PUSH, 3'd2, 16'h5555, 32'h5555_5555);
        send_word(ptmhq_pkg::CMD_PUSH, 3'd5, 16'hAAAA, 32'hAAAA_AAAA);
        send_word(ptmhq_pkg::CMD_PUSH, 3'd0, 16'd0, 32'h1234_5678);
        repeat (11)
            send_word(ptmhq_pkg::CMD_POP, 3'd0, 16'd0, 32'h0);
        send_word(ptmhq_pkg::CMD_POP, 3'd0, 16'd0, 32'h0);
        drain_results();

        // random bursts: fill, drain or churn, with keys steered toward ties
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            case ($urandom_range(2))
                0:       push_pct = 90;
                1:       push_pct = 10;
                default: push_pct = 50;
            endcase
            burst_len = $urandom_range(130, 30);
            for (int k = 0; k < burst_len && sent < RANDOM_WORDS; k++)
            begin
                // idling phases, each entered with the heap's results all back
                if (sent == RANDOM_WORDS / 3)
                begin
                    drain_results();
                    idle_pct = 73;
                end
                else if (sent == 2 * RANDOM_WORDS / 3)
                begin
                    drain_results();
                    idle_pct = 0;
                end
                op = ($urandom_range(99) < push_pct) ? ptmhq_pkg::CMD_PUSH
                                                     : ptmhq_pkg::CMD_POP;
                case ($urandom_range(3))
                    0:
                    begin
                        p = ptmhq_pkg::PRIO_W'($urandom_range(7));
                        t = ptmhq_pkg::TTL_W'($urandom);
                    end
                    1:
                    begin
                        p = ptmhq_pkg::PRIO_W'($urandom_range(7));
                        t = ptmhq_pkg::TTL_W'($urandom_range(3));
                    end
                    2:
                    begin
                        p = ptmhq_pkg::PRIO_W'($urandom_range(7));
                        t = ptmhq_pkg::TTL_W'(10000 * $urandom_range(6));
                    end
                    default:
                    begin
                        p = $urandom_range(1) ? 3'd7 : 3'd0;
                        t = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    end
                endcase
                send_word(op, p, t, $urandom);
                sent++;
            end
        end

        // let the last results come back, then a short quiet tail
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d words; %0d pushes stored, %0d refused as full, %0d pops served,",
                 words_sent, push_total, full_total, pop_total);
        $display("     %0d pops on an empty heap, occupancy peaked at %0d",
                 empty_total, peak_occupancy);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/ptmhq_pkg.sv
rtl/ptmhq_ram.sv
rtl/ptmhq_ctrl.sv
rtl/ptmhq_dpath.sv
rtl/priority_ttl_min_heap_queue_top.sv
test/ptmhq_checker.sv
test/tb_priority_ttl_min_heap_queue_top.sv
